@@ src/btok_pkg.sv @@
// Package for the byte stream tokenizer.
// Holds the token kinds, lexer mode codes, character codes and shared types.
// No dependencies.
package btok_pkg;

    // Token kinds carried on every result
    localparam logic [3:0] K_EQUALS  = 4'd0;
    localparam logic [3:0] K_SEMI    = 4'd1;
    localparam logic [3:0] K_OPEN    = 4'd2;
    localparam logic [3:0] K_CLOSE   = 4'd3;
    localparam logic [3:0] K_LINEEND = 4'd4;
    localparam logic [3:0] K_MINUS   = 4'd5;
    localparam logic [3:0] K_DOT     = 4'd6;
    localparam logic [3:0] K_SPACE   = 4'd7;
    localparam logic [3:0] K_STRING  = 4'd8;
    localparam logic [3:0] K_NUMBER  = 4'd9;
    localparam logic [3:0] K_IDENT   = 4'd10;
    localparam logic [3:0] K_OTHER   = 4'd11;
    localparam logic [3:0] K_EOF     = 4'd12;

    // Lexer modes (which token is open)
    localparam logic [2:0] MODE_IDLE   = 3'd0;
    localparam logic [2:0] MODE_SPACE  = 3'd1;
    localparam logic [2:0] MODE_STRING = 3'd2;
    localparam logic [2:0] MODE_NUMBER = 3'd3;
    localparam logic [2:0] MODE_IDENT  = 3'd4;

    // Character codes
    localparam logic [7:0] CH_EQUALS = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_OPEN   = 8'h5B;
    localparam logic [7:0] CH_CLOSE  = 8'h5D;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // Result slots per request; one input request causes at most 3 results
    localparam int MAX_RES = 4;

    // Lexer state kept between requests
    typedef struct packed {
        logic [2:0] mode;
        logic [7:0] held_byte;
        logic       held_valid;
        logic       quote_single;
        logic       escape_pending;
    } t_state;

    // One result item
    typedef struct packed {
        logic       event_res;
        logic [3:0] token_kind;
        logic [7:0] text_byte;
        logic       last;
    } t_result;

    function automatic logic is_digit(input logic [7:0] b);
        return (b >= 8'h30) && (b <= 8'h39);
    endfunction

    function automatic logic is_alpha(input logic [7:0] b);
        return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
    endfunction

    // space, tab, vertical tab, form feed, carriage return
    function automatic logic is_blank(input logic [7:0] b);
        return (b == 8'h20) || (b == 8'h09) || (b == 8'h0B) || (b == 8'h0C) ||
               (b == 8'h0D);
    endfunction

    // Build a result; markers carry a zero text byte
    function automatic t_result mk_res(input logic ev, input logic [3:0] kind,
                                       input logic [7:0] b);
        t_result r;
        r.event_res  = ev;
        r.token_kind = kind;
        r.text_byte  = ev ? 8'h00 : b;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

@@ src/btok_lexer.sv @@
// Combinational lexer step: one byte or end-of-input against the current state.
// Produces the next state and up to btok_pkg::MAX_RES results in order.
// Depends on btok_pkg.
module btok_lexer (
    input  btok_pkg::t_state                           i_state,
    input  logic [7:0]                                 i_byte,
    input  logic                                       i_eoi,
    output btok_pkg::t_state                           o_state,
    output btok_pkg::t_result [btok_pkg::MAX_RES-1:0]  o_res,
    output logic [$clog2(btok_pkg::MAX_RES+1)-1:0]     o_count
);

    localparam int CW = $clog2(btok_pkg::MAX_RES + 1);
    localparam int IW = $clog2(btok_pkg::MAX_RES);

    btok_pkg::t_state                          n_st;
    btok_pkg::t_result [btok_pkg::MAX_RES-1:0] res;
    logic [CW-1:0]                             cnt;
    logic                                      do_start;
    logic [7:0]                                quote;
    logic [3:0]                                held_kind;

    assign quote     = i_state.quote_single ? btok_pkg::CH_SQUOTE : btok_pkg::CH_DQUOTE;
    assign held_kind = (i_state.held_byte == btok_pkg::CH_MINUS) ?
                       btok_pkg::K_MINUS : btok_pkg::K_DOT;

    // Walk the request, appending results in output order
    always_comb begin
        n_st     = i_state;
        res      = '0;
        cnt      = '0;
        do_start = 1'b0;

        if (i_eoi) begin
            // close whatever is open, then end-of-file
            if (i_state.held_valid) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, held_kind, 8'h00);
                cnt = cnt + 1'b1;
            end else begin
                unique case (i_state.mode)
                    btok_pkg::MODE_SPACE: begin
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_SPACE, 8'h00);
                        cnt = cnt + 1'b1;
                    end
                    btok_pkg::MODE_STRING: begin
                        if (i_state.escape_pending) begin
                            res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_STRING,
                                                                btok_pkg::CH_BSLASH);
                            cnt = cnt + 1'b1;
                        end
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_STRING, 8'h00);
                        cnt = cnt + 1'b1;
                    end
                    btok_pkg::MODE_NUMBER: begin
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_NUMBER, 8'h00);
                        cnt = cnt + 1'b1;
                    end
                    btok_pkg::MODE_IDENT: begin
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_IDENT, 8'h00);
                        cnt = cnt + 1'b1;
                    end
                    default: ;
                endcase
            end
            res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_EOF, 8'h00);
            cnt  = cnt + 1'b1;
            n_st = '0;
        end else if (i_state.held_valid) begin
            // lookahead decides between a number and a lone minus or dot
            n_st.held_valid = 1'b0;
            if (btok_pkg::is_digit(i_byte)) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_NUMBER,
                                                    i_state.held_byte);
                cnt = cnt + 1'b1;
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_NUMBER, i_byte);
                cnt = cnt + 1'b1;
                n_st.mode = btok_pkg::MODE_NUMBER;
            end else begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, held_kind, 8'h00);
                cnt = cnt + 1'b1;
                do_start = 1'b1;
            end
        end else begin
            unique case (i_state.mode)
                btok_pkg::MODE_SPACE: begin
                    if (btok_pkg::is_blank(i_byte)) begin
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_SPACE, i_byte);
                        cnt = cnt + 1'b1;
                    end else begin
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_SPACE, 8'h00);
                        cnt = cnt + 1'b1;
                        do_start = 1'b1;
                    end
                end
                btok_pkg::MODE_STRING: begin
                    if (i_state.escape_pending && (i_byte == quote)) begin
                        // escaped quote is plain text
                        n_st.escape_pending = 1'b0;
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_STRING, i_byte);
                        cnt = cnt + 1'b1;
                    end else begin
                        if (i_state.escape_pending) begin
                            n_st.escape_pending = 1'b0;
                            res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_STRING,
                                                                btok_pkg::CH_BSLASH);
                            cnt = cnt + 1'b1;
                        end
                        if (i_byte == quote) begin
                            res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_STRING,
                                                                8'h00);
                            cnt = cnt + 1'b1;
                            n_st.mode = btok_pkg::MODE_IDLE;
                        end else if (i_byte == btok_pkg::CH_BSLASH) begin
                            n_st.escape_pending = 1'b1;
                        end else begin
                            res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_STRING,
                                                                i_byte);
                            cnt = cnt + 1'b1;
                        end
                    end
                end
                btok_pkg::MODE_NUMBER: begin
                    if (btok_pkg::is_alpha(i_byte) || btok_pkg::is_digit(i_byte) ||
                        (i_byte == btok_pkg::CH_DOT)) begin
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_NUMBER, i_byte);
                        cnt = cnt + 1'b1;
                    end else begin
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_NUMBER, 8'h00);
                        cnt = cnt + 1'b1;
                        do_start = 1'b1;
                    end
                end
                btok_pkg::MODE_IDENT: begin
                    if (btok_pkg::is_alpha(i_byte) || btok_pkg::is_digit(i_byte) ||
                        (i_byte == btok_pkg::CH_UNDER)) begin
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_IDENT, i_byte);
                        cnt = cnt + 1'b1;
                    end else begin
                        res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_IDENT, 8'h00);
                        cnt = cnt + 1'b1;
                        do_start = 1'b1;
                    end
                end
                default: do_start = 1'b1;
            endcase
        end

        // open a new token with the current byte
        if (do_start) begin
            n_st.mode = btok_pkg::MODE_IDLE;
            priority if (i_byte == btok_pkg::CH_EQUALS) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_EQUALS, 8'h00);
                cnt = cnt + 1'b1;
            end else if (i_byte == btok_pkg::CH_SEMI) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_SEMI, 8'h00);
                cnt = cnt + 1'b1;
            end else if (i_byte == btok_pkg::CH_OPEN) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_OPEN, 8'h00);
                cnt = cnt + 1'b1;
            end else if (i_byte == btok_pkg::CH_CLOSE) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_CLOSE, 8'h00);
                cnt = cnt + 1'b1;
            end else if (i_byte == btok_pkg::CH_NL) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_LINEEND, 8'h00);
                cnt = cnt + 1'b1;
            end else if ((i_byte == btok_pkg::CH_MINUS) || (i_byte == btok_pkg::CH_DOT)) begin
                n_st.held_byte  = i_byte;
                n_st.held_valid = 1'b1;
            end else if (btok_pkg::is_blank(i_byte)) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_SPACE, i_byte);
                cnt = cnt + 1'b1;
                n_st.mode = btok_pkg::MODE_SPACE;
            end else if ((i_byte == btok_pkg::CH_DQUOTE) || (i_byte == btok_pkg::CH_SQUOTE)) begin
                n_st.mode           = btok_pkg::MODE_STRING;
                n_st.quote_single   = (i_byte == btok_pkg::CH_SQUOTE);
                n_st.escape_pending = 1'b0;
            end else if (btok_pkg::is_digit(i_byte)) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_NUMBER, i_byte);
                cnt = cnt + 1'b1;
                n_st.mode = btok_pkg::MODE_NUMBER;
            end else if (btok_pkg::is_alpha(i_byte) || (i_byte == btok_pkg::CH_UNDER)) begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_IDENT, i_byte);
                cnt = cnt + 1'b1;
                n_st.mode = btok_pkg::MODE_IDENT;
            end else begin
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b0, btok_pkg::K_OTHER, i_byte);
                cnt = cnt + 1'b1;
                res[cnt[IW-1:0]] = btok_pkg::mk_res(1'b1, btok_pkg::K_OTHER, 8'h00);
                cnt = cnt + 1'b1;
            end
        end

        // flag the final result of this request
        for (int i = 0; i < btok_pkg::MAX_RES; i++) begin
            res[i].last = (cnt != '0) && (CW'(i) == (cnt - 1'b1));
        end
    end

    assign o_state = n_st;
    assign o_res   = res;
    assign o_count = cnt;

endmodule

@@ src/byte_stream_tokenizer_top.sv @@
// Byte stream tokenizer, top level.
// Input register, lexer step and a small result buffer, drained one result per ready cycle.
// Depends on btok_pkg and btok_lexer.
//
//  channel   | direction | tdata              | tuser                       | tlast
//  ----------+-----------+--------------------+-----------------------------+--------------
//  s_axis    | in        | [7:0] byte_value   | [0] end_of_input            | -
//  m_axis    | out       | [7:0] text_byte    | [0] event_res, [4:1] kind   | last_of_input
//
// One request is registered, then lexed combinationally into the result buffer.
// Each request leaves 0 to 3 results; the buffer sends one per cycle while the output is
// ready, so the input then takes a request every cycle while requests give at most one
// result, and otherwise waits until the buffer drains to its last result.
// Results pass through the input register and the result buffer before they appear.
// Synchronous active-low reset clears the lexer state, input valid and buffer count.
// A stalled output holds its result; the input stalls while a registered request
// waits for the buffer to drain down to its last result.
module byte_stream_tokenizer_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,    // [7:0] byte_value
    input  logic       s_axis_tuser,    // [0] end_of_input
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,    // [7:0] text_byte
    output logic [4:0] m_axis_tuser,    // [0] event_res, [4:1] token_kind
    output logic       m_axis_tlast     // last_of_input
);

    localparam int CW = $clog2(btok_pkg::MAX_RES + 1);

    btok_pkg::t_state                          r_state, n_state;
    logic                                      r_in_valid;
    logic [7:0]                                r_in_byte;
    logic                                      r_in_eoi;
    btok_pkg::t_result [btok_pkg::MAX_RES-1:0] r_res, w_res;
    logic [CW-1:0]                             r_cnt, w_count;
    logic                                      w_drain;
    logic                                      w_advance;
    logic                                      w_buf_free;

    // Handshake control
    assign w_drain       = m_axis_tvalid && m_axis_tready;
    assign w_buf_free    = (r_cnt == '0) || ((r_cnt == CW'(1)) && w_drain);
    assign w_advance     = r_in_valid && w_buf_free;
    assign s_axis_tready = !r_in_valid || w_advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eoi  <= s_axis_tuser;
        end
    end

    btok_lexer u_lexer (
        .i_state (r_state),
        .i_byte  (r_in_byte),
        .i_eoi   (r_in_eoi),
        .o_state (n_state),
        .o_res   (w_res),
        .o_count (w_count)
    );

    // Lexer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (w_advance) begin
            r_state <= n_state;
        end
    end

    // Result buffer: load a request's results, shift down on each delivery
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (w_advance) begin
            r_cnt <= w_count;
        end else if (w_drain) begin
            r_cnt <= r_cnt - 1'b1;
        end
        if (w_advance) begin
            r_res <= w_res;
        end else if (w_drain) begin
            for (int i = 0; i < btok_pkg::MAX_RES - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

    assign m_axis_tvalid = (r_cnt != '0);
    assign m_axis_tdata  = r_res[0].text_byte;
    assign m_axis_tuser  = {r_res[0].token_kind, r_res[0].event_res};
    assign m_axis_tlast  = r_res[0].last;

    // Checks
    a_no_load_over_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt > CW'(1)) |-> !w_advance)
        else $error("lexer advanced while results were still queued");

    a_last_closes_group: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == CW'(1)) |-> m_axis_tlast)
        else $error("final queued result lacks its last flag");

    a_held_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.held_valid |-> (r_state.mode == btok_pkg::MODE_IDLE))
        else $error("held sign byte while a token is open");

    a_escape_in_string: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.escape_pending |-> (r_state.mode == btok_pkg::MODE_STRING))
        else $error("escape pending outside a string");

    a_eof_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_in_eoi) |=>
            ((r_state.mode == btok_pkg::MODE_IDLE) && !r_state.held_valid &&
             (m_axis_tvalid && (m_axis_tuser[0] == 1'b1) || r_cnt > CW'(1))))
        else $error("end of input did not return the lexer to idle");

endmodule

@@ tb/tb_byte_stream_tokenizer_top.sv @@
// Self-checking testbench for byte_stream_tokenizer_top.
// Feeds byte and end-of-input requests, predicts the token result stream and checks it.
// Depends on btok_pkg and byte_stream_tokenizer_top.
`timescale 1ns / 1ps

module tb_byte_stream_tokenizer_top;

    // Blank and digit bounds used by the predictor
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Receiver ready patterns
    localparam int RDY_ALWAYS = 0;
    localparam int RDY_RANDOM = 1;
    localparam int RDY_EVERY3 = 2;

    localparam int RANDOM_ITEMS = 75;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 20;

    typedef struct packed {
        logic [7:0] byte_value;
        logic       end_of_input;
    } t_byte_req;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // [7:0] byte_value
    logic       s_axis_tuser = 1'b0;    // [0] end_of_input
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;           // [7:0] text_byte
    logic [4:0] m_axis_tuser;           // [0] event_res, [4:1] token_kind
    logic       m_axis_tlast;           // last_of_input

    byte_stream_tokenizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    t_byte_req         pending_bytes[$];
    btok_pkg::t_result expected_tokens[$];

    int  fail_count = 0;
    int  taken_count = 0;
    bit  req_taken = 1'b0;
    bit  hold_off = 1'b0;
    int  burst_left = 0;
    int  gap_left = 0;
    int  rdy_mode = RDY_ALWAYS;
    int  rdy_left = 0;
    int  rdy_phase = 0;

    // Lexer state mirrored by the predictor
    logic [2:0] lx_mode = btok_pkg::MODE_IDLE;
    logic [7:0] lx_held = 8'h00;
    logic       lx_held_valid = 1'b0;
    logic       lx_single = 1'b0;
    logic       lx_escape = 1'b0;

    // ---------------------------------------------------------------
    // Character classes
    // ---------------------------------------------------------------
    function automatic bit digit_ch(logic [7:0] b);
        return b >= CH_ZERO && b <= CH_NINE;
    endfunction

    function automatic bit letter_ch(logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic bit blank_ch(logic [7:0] b);
        return b == CH_SPACE || b == CH_TAB || b == CH_VT || b == CH_FF || b == CH_CR;
    endfunction

    // ---------------------------------------------------------------
    // Token predictor
    // ---------------------------------------------------------------
    function automatic void add_token(logic ev, logic [3:0] kind, logic [7:0] b);
        btok_pkg::t_result r;
        r.event_res  = ev;
        r.token_kind = kind;
        r.text_byte  = ev ? 8'h00 : b;
        r.last       = 1'b0;
        expected_tokens.push_back(r);
    endfunction

    function automatic logic [3:0] held_kind();
        return (lx_held == btok_pkg::CH_MINUS) ? btok_pkg::K_MINUS : btok_pkg::K_DOT;
    endfunction

    // Byte seen with no token open
    function automatic void open_token(logic [7:0] b);
        case (b)
            btok_pkg::CH_EQUALS: add_token(1'b1, btok_pkg::K_EQUALS, 8'h00);
            btok_pkg::CH_SEMI:   add_token(1'b1, btok_pkg::K_SEMI, 8'h00);
            btok_pkg::CH_OPEN:   add_token(1'b1, btok_pkg::K_OPEN, 8'h00);
            btok_pkg::CH_CLOSE:  add_token(1'b1, btok_pkg::K_CLOSE, 8'h00);
            btok_pkg::CH_NL:     add_token(1'b1, btok_pkg::K_LINEEND, 8'h00);
            btok_pkg::CH_MINUS, btok_pkg::CH_DOT: begin
                lx_held = b;
                lx_held_valid = 1'b1;
            end
            default: begin
                if (blank_ch(b)) begin
                    add_token(1'b0, btok_pkg::K_SPACE, b);
                    lx_mode = btok_pkg::MODE_SPACE;
                end else if (b == btok_pkg::CH_DQUOTE || b == btok_pkg::CH_SQUOTE) begin
                    lx_mode = btok_pkg::MODE_STRING;
                    lx_single = (b == btok_pkg::CH_SQUOTE);
                    lx_escape = 1'b0;
                end else if (digit_ch(b)) begin
                    add_token(1'b0, btok_pkg::K_NUMBER, b);
                    lx_mode = btok_pkg::MODE_NUMBER;
                end else if (letter_ch(b) || b == btok_pkg::CH_UNDER) begin
                    add_token(1'b0, btok_pkg::K_IDENT, b);
                    lx_mode = btok_pkg::MODE_IDENT;
                end else begin
                    add_token(1'b0, btok_pkg::K_OTHER, b);
                    add_token(1'b1, btok_pkg::K_OTHER, 8'h00);
                end
            end
        endcase
    endfunction

    // Byte inside an open string
    function automatic void string_step(logic [7:0] b);
        logic [7:0] q;
        q = lx_single ? btok_pkg::CH_SQUOTE : btok_pkg::CH_DQUOTE;
        if (lx_escape) begin
            lx_escape = 1'b0;
            if (b == q) begin
                add_token(1'b0, btok_pkg::K_STRING, b);
                return;
            end
            add_token(1'b0, btok_pkg::K_STRING, btok_pkg::CH_BSLASH);
        end
        if (b == q) begin
            add_token(1'b1, btok_pkg::K_STRING, 8'h00);
            lx_mode = btok_pkg::MODE_IDLE;
        end else if (b == btok_pkg::CH_BSLASH) begin
            lx_escape = 1'b1;
        end else begin
            add_token(1'b0, btok_pkg::K_STRING, b);
        end
    endfunction

    function automatic void lex_byte(logic [7:0] b);
        // Held minus or dot resolved by this byte
        if (lx_held_valid) begin
            lx_held_valid = 1'b0;
            if (digit_ch(b)) begin
                add_token(1'b0, btok_pkg::K_NUMBER, lx_held);
                add_token(1'b0, btok_pkg::K_NUMBER, b);
                lx_mode = btok_pkg::MODE_NUMBER;
            end else begin
                add_token(1'b1, held_kind(), 8'h00);
                open_token(b);
            end
            return;
        end
        case (lx_mode)
            btok_pkg::MODE_SPACE: begin
                if (blank_ch(b)) begin
                    add_token(1'b0, btok_pkg::K_SPACE, b);
                    return;
                end
                add_token(1'b1, btok_pkg::K_SPACE, 8'h00);
            end
            btok_pkg::MODE_STRING: begin
                string_step(b);
                return;
            end
            btok_pkg::MODE_NUMBER: begin
                if (letter_ch(b) || digit_ch(b) || b == btok_pkg::CH_DOT) begin
                    add_token(1'b0, btok_pkg::K_NUMBER, b);
                    return;
                end
                add_token(1'b1, btok_pkg::K_NUMBER, 8'h00);
            end
            btok_pkg::MODE_IDENT: begin
                if (letter_ch(b) || digit_ch(b) || b == btok_pkg::CH_UNDER) begin
                    add_token(1'b0, btok_pkg::K_IDENT, b);
                    return;
                end
                add_token(1'b1, btok_pkg::K_IDENT, 8'h00);
            end
            default: ;
        endcase
        lx_mode = btok_pkg::MODE_IDLE;
        open_token(b);
    endfunction

    // End of input: close what is open, then the eof marker
    function automatic void lex_end();
        if (lx_held_valid) begin
            add_token(1'b1, held_kind(), 8'h00);
        end else begin
            case (lx_mode)
                btok_pkg::MODE_SPACE:  add_token(1'b1, btok_pkg::K_SPACE, 8'h00);
                btok_pkg::MODE_STRING: begin
                    if (lx_escape) add_token(1'b0, btok_pkg::K_STRING, btok_pkg::CH_BSLASH);
                    add_token(1'b1, btok_pkg::K_STRING, 8'h00);
                end
                btok_pkg::MODE_NUMBER: add_token(1'b1, btok_pkg::K_NUMBER, 8'h00);
                btok_pkg::MODE_IDENT:  add_token(1'b1, btok_pkg::K_IDENT, 8'h00);
                default: ;
            endcase
        end
        add_token(1'b1, btok_pkg::K_EOF, 8'h00);
        lx_mode = btok_pkg::MODE_IDLE;
        lx_held_valid = 1'b0;
        lx_held = 8'h00;
        lx_single = 1'b0;
        lx_escape = 1'b0;
    endfunction

    function automatic void predict_tokens(logic eoi, logic [7:0] b);
        int n0;
        btok_pkg::t_result r;
        n0 = expected_tokens.size();
        if (eoi) lex_end();
        else lex_byte(b);
        // Flag the last result of this request
        if (expected_tokens.size() > n0) begin
            r = expected_tokens.pop_back();
            r.last = 1'b1;
            expected_tokens.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic void push_byte(logic [7:0] b);
        t_byte_req it;
        it.byte_value = b;
        it.end_of_input = 1'b0;
        pending_bytes.push_back(it);
    endfunction

    function automatic void push_text(string s);
        for (int i = 0; i < s.len(); i++) push_byte(s[i]);
    endfunction

    // Byte lane carries junk on end-of-input; the block must ignore it
    function automatic void push_eof();
        t_byte_req it;
        it.byte_value = 8'($urandom_range(0, 255));
        it.end_of_input = 1'b1;
        pending_bytes.push_back(it);
    endfunction

    function automatic logic [7:0] pick(string set);
        return set[$urandom_range(0, set.len() - 1)];
    endfunction

    // Random token sequences, mostly well formed
    task automatic gen_random(int count);
        string letters;
        string alnum;
        string puncts;
        logic [7:0] q;
        int stop;
        letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
        alnum   = "abcxyzABCXYZ0123456789";
        puncts  = "!#$%&()*+,/:<>?@^`{|}~";
        stop = pending_bytes.size() + count;
        while (pending_bytes.size() < stop) begin
            case ($urandom_range(0, 19))
                0, 1: push_byte(pick("=;[]\n"));
                2, 3: begin
                    // space, tab, carriage return, vertical tab, form feed
                    repeat ($urandom_range(1, 4))
                        push_byte(pick(" \t\r\013\014"));
                end
                4, 5, 6: begin
                    push_byte(pick({letters, "_"}));
                    repeat ($urandom_range(0, 5)) push_byte(pick({alnum, "_"}));
                end
                7, 8, 9: begin
                    if ($urandom_range(0, 2) == 0) push_byte(pick("-."));
                    push_byte(pick("0123456789"));
                    repeat ($urandom_range(0, 5)) push_byte(pick({alnum, "."}));
                end
                10, 11, 12: begin
                    q = $urandom_range(0, 1) ? btok_pkg::CH_SQUOTE : btok_pkg::CH_DQUOTE;
                    push_byte(q);
                    repeat ($urandom_range(0, 6)) begin
                        case ($urandom_range(0, 5))
                            0: begin
                                push_byte(btok_pkg::CH_BSLASH);
                                push_byte(q);
                            end
                            1: begin
                                push_byte(btok_pkg::CH_BSLASH);
                                push_byte(pick({alnum, "\\\"'"}));
                            end
                            2: push_byte(q == btok_pkg::CH_SQUOTE ? btok_pkg::CH_DQUOTE
                                                                 : btok_pkg::CH_SQUOTE);
                            default: push_byte(8'($urandom_range(0, 255)));
                        endcase
                    end
                    // Now and then leave the string open up to the end of input
                    if ($urandom_range(0, 7) == 0) begin
                        if ($urandom_range(0, 1)) push_byte(btok_pkg::CH_BSLASH);
                        push_eof();
                    end else begin
                        push_byte(q);
                    end
                end
                13, 14: push_byte(pick("-."));
                15, 16: begin
                    if ($urandom_range(0, 1)) push_byte(8'($urandom_range(128, 255)));
                    else push_byte(pick(puncts));
                end
                17, 18: push_byte(8'($urandom_range(0, 255)));
                default: push_eof();
            endcase
        end
        push_eof();
    endtask

    // ---------------------------------------------------------------
    // Sender: bursts with random gaps, changes at the falling edge
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : drv
        t_byte_req it;
        logic nv;
        nv = s_axis_tvalid;
        if (!i_rst_n) begin
            nv = 1'b0;
        end else begin
            if (req_taken) nv = 1'b0;
            if (!nv) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_bytes.size() > 0) begin
                    it = pending_bytes.pop_front();
                    s_axis_tdata <= it.byte_value;
                    s_axis_tuser <= it.end_of_input;
                    nv = 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
        s_axis_tvalid <= nv;
    end

    // ---------------------------------------------------------------
    // Receiver: ready pattern switches at random between always, random and periodic
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin : rcv
        logic rdy;
        if (rdy_left == 0) begin
            rdy_mode = $urandom_range(RDY_ALWAYS, RDY_EVERY3);
            rdy_left = $urandom_range(10, 40);
        end else begin
            rdy_left--;
        end
        case (rdy_mode)
            RDY_ALWAYS: rdy = 1'b1;
            RDY_RANDOM: rdy = 1'($urandom_range(0, 1));
            default:    rdy = (rdy_phase % 3 == 0);
        endcase
        rdy_phase++;
        if (hold_off) rdy = 1'b0;
        m_axis_tready <= rdy;
    end

    // Long hold-off on the output while the sender keeps offering requests
    initial begin
        while (taken_count < HOLD_AFTER) @(posedge i_clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_off = 1'b0;
    end

    // ---------------------------------------------------------------
    // Monitor: check results, predict from accepted requests
    // ---------------------------------------------------------------
    always @(posedge i_clk) begin : mon
        btok_pkg::t_result want;
        req_taken = 1'b0;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_tokens.size() == 0) begin
                    $error("unexpected result: event %0d kind %0d byte %02h last %0d",
                           m_axis_tuser[0], m_axis_tuser[4:1], m_axis_tdata, m_axis_tlast);
                    fail_count++;
                end else begin
                    want = expected_tokens.pop_front();
                    if (m_axis_tuser[0] !== want.event_res) begin
                        $error("event_res: expected %0d, got %0d",
                               want.event_res, m_axis_tuser[0]);
                        fail_count++;
                    end
                    if (m_axis_tuser[4:1] !== want.token_kind) begin
                        $error("token_kind: expected %0d, got %0d",
                               want.token_kind, m_axis_tuser[4:1]);
                        fail_count++;
                    end
                    if (m_axis_tdata !== want.text_byte) begin
                        $error("text_byte: expected %02h, got %02h",
                               want.text_byte, m_axis_tdata);
                        fail_count++;
                    end
                    if (m_axis_tlast !== want.last) begin
                        $error("last_of_input: expected %0d, got %0d",
                               want.last, m_axis_tlast);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                predict_tokens(s_axis_tuser, s_axis_tdata);
                taken_count++;
                req_taken = 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin
        // Directed: single-byte tokens, minus into number, space, dot then ident
        push_text("=;[]\n-5 .a");
        // Byte extremes and high bytes as other tokens
        push_byte(8'h00);
        push_byte(8'hFF);
        push_byte(8'h80);
        // Single-quoted string: escaped quote, backslash before an ordinary byte
        push_text("'\\'\\x'");
        // End of input inside a string with an escape pending
        push_text("\"\\");
        push_eof();
        // End of input with a held minus, then on an idle lexer
        push_text("-");
        push_eof();
        push_eof();

        gen_random(RANDOM_ITEMS);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("byte_stream_tokenizer_top regression: pass");
        end else begin
            $display("byte_stream_tokenizer_top regression: fail");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #2ms;
        $display("byte_stream_tokenizer_top regression: fail");
        $finish;
    end

endmodule
